[rtl/core/rcsfd_pkg.sv]
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared constants, types and controller state for the satellite frame decoder.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

    // frame geometry
    localparam int FRAME_BYTES     = 16;
    localparam int WORDS_PER_FRAME = 7;

    localparam int ADDR_W = $clog2(FRAME_BYTES);                // store address
    localparam int POS_W  = $clog2(2 * WORDS_PER_FRAME + 2);    // word byte position
    localparam int WORD_W = $clog2(WORDS_PER_FRAME + 1);        // word counter

    // field widths
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int GAP_W   = 16;
    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 11;

    // header and mode
    localparam logic [BYTE_W-1:0] STATUS_FIRST  = 8'h03;
    localparam logic [BYTE_W-1:0] STATUS_SECOND = 8'hB2;
    localparam int                MODE_BIT      = 4;
    localparam logic [GAP_W-1:0]  GAP_RESET     = 16'd2500;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_HI,
        ST_RD_LO,
        ST_LOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;
        logic commit_frame;
        logic byte_sel;      // 0: high byte of the word, 1: low byte
        logic latch_hi;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic frame_full;
        logic hdr_ok;
        logic word_last;
        logic out_busy;
    } t_sts;

endpackage

[rtl/core/rcsfd_ram.sv]
// ----------------------------------------------------------------------------
// rcsfd_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rcsfd_ctrl.sv]
// ----------------------------------------------------------------------------
// rcsfd_ctrl
// Controller: byte intake, header check and per-word read/emit sequencing.
// ----------------------------------------------------------------------------
module rcsfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rcsfd_pkg::t_sts  i_sts,
    output rcsfd_pkg::t_cmd  o_cmd
);

    rcsfd_pkg::t_state r_state;
    rcsfd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcsfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rcsfd_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.frame_full) begin
                    n_state = rcsfd_pkg::ST_CHECK;
                end
            end
            rcsfd_pkg::ST_CHECK: begin
                n_state = i_sts.hdr_ok ? rcsfd_pkg::ST_RD_HI : rcsfd_pkg::ST_IDLE;
            end
            rcsfd_pkg::ST_RD_HI: n_state = rcsfd_pkg::ST_RD_LO;
            rcsfd_pkg::ST_RD_LO: n_state = rcsfd_pkg::ST_LOAD;
            rcsfd_pkg::ST_LOAD: begin
                if (!i_sts.out_busy) begin
                    n_state = i_sts.word_last ? rcsfd_pkg::ST_IDLE : rcsfd_pkg::ST_RD_HI;
                end
            end
            default: n_state = rcsfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            rcsfd_pkg::ST_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.take_byte = i_in_valid;
            end
            rcsfd_pkg::ST_CHECK: begin
                o_cmd.commit_frame = i_sts.hdr_ok;
            end
            rcsfd_pkg::ST_RD_HI: begin
                o_cmd.byte_sel = 1'b0;
            end
            rcsfd_pkg::ST_RD_LO: begin
                o_cmd.byte_sel = 1'b1;
                o_cmd.latch_hi = 1'b1;
            end
            rcsfd_pkg::ST_LOAD: begin
                o_cmd.byte_sel = 1'b1;      // hold address so read data stays
                o_cmd.load_out = !i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/rcsfd_dp.sv]
// ----------------------------------------------------------------------------
// rcsfd_dp
// Datapath: gap test, frame store, header registers, word decode, result reg.
// ----------------------------------------------------------------------------
module rcsfd_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rcsfd_pkg::GAP_W-1:0]            i_cfg_wdata,
    input  logic [rcsfd_pkg::BYTE_W-1:0]           i_rx_byte,
    input  logic [rcsfd_pkg::TIME_W-1:0]           i_time_now,
    input  rcsfd_pkg::t_cmd                        i_cmd,
    output rcsfd_pkg::t_sts                        o_sts,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic [rcsfd_pkg::CHAN_W-1:0]           o_channel_index,
    output logic signed [rcsfd_pkg::VALUE_W-1:0]   o_channel_value,
    output logic [rcsfd_pkg::TIME_W-1:0]           o_frame_interval,
    output logic                                   o_frame_last
);

    // control state
    logic [rcsfd_pkg::GAP_W-1:0]   r_gap_limit;
    logic [rcsfd_pkg::ADDR_W-1:0]  r_byte_count, n_byte_count;
    logic [rcsfd_pkg::TIME_W-1:0]  r_last_byte_time;
    logic [rcsfd_pkg::TIME_W-1:0]  r_last_frame_time;
    logic [rcsfd_pkg::WORD_W-1:0]  r_word;
    logic                          r_out_valid;

    // payload
    logic [rcsfd_pkg::BYTE_W-1:0]  r_s1, r_s2, r_hi;
    logic [rcsfd_pkg::TIME_W-1:0]  r_now, r_interval;
    logic                          r_rd_zero;
    logic [rcsfd_pkg::CHAN_W-1:0]  r_chan;
    logic [rcsfd_pkg::VALUE_W-1:0] r_value;
    logic [rcsfd_pkg::TIME_W-1:0]  r_res_interval;   // interval held with the result
    logic                          r_last;

    logic [rcsfd_pkg::TIME_W-1:0]  gap;
    logic [rcsfd_pkg::ADDR_W-1:0]  cnt_eff;
    logic                          full;
    logic [rcsfd_pkg::POS_W-1:0]   pos;
    logic                          pos_out;
    logic [rcsfd_pkg::ADDR_W-1:0]  raddr;
    logic [rcsfd_pkg::BYTE_W-1:0]  rdata, rd_byte;
    logic [15:0]                   word;
    logic                          ten_bit;
    logic [rcsfd_pkg::CHAN_W-1:0]  chan;
    logic [rcsfd_pkg::VALUE_W-1:0] value;

    // gap test and store position of the incoming byte
    always_comb begin
        gap     = i_time_now - r_last_byte_time;
        cnt_eff = (gap > {{(rcsfd_pkg::TIME_W-rcsfd_pkg::GAP_W){1'b0}}, r_gap_limit})
                  ? '0 : r_byte_count;
        full    = (cnt_eff == rcsfd_pkg::ADDR_W'(rcsfd_pkg::FRAME_BYTES - 1));
        n_byte_count = full ? '0 : cnt_eff + 1'b1;
    end

    // byte position of the current word half; beyond the frame reads as zero
    always_comb begin
        pos     = rcsfd_pkg::POS_W'(2) + {r_word, 1'b0} + rcsfd_pkg::POS_W'(i_cmd.byte_sel);
        pos_out = (32'(pos) >= rcsfd_pkg::FRAME_BYTES);
        raddr   = rcsfd_pkg::ADDR_W'(pos);
    end

    rcsfd_ram #(
        .WIDTH (rcsfd_pkg::BYTE_W),
        .DEPTH (rcsfd_pkg::FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take_byte),
        .i_waddr (cnt_eff),
        .i_wdata (i_rx_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_byte = r_rd_zero ? '0 : rdata;

    // word decode; offset removal is an MSB flip
    always_comb begin
        word    = {r_hi, rd_byte};
        ten_bit = r_s2[rcsfd_pkg::MODE_BIT];
        if (ten_bit) begin
            chan  = word[13:10];
            value = {~word[9], word[8:0], 1'b0};
        end else begin
            chan  = word[14:11];
            value = {~word[10], word[9:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit       <= rcsfd_pkg::GAP_RESET;
            r_byte_count      <= '0;
            r_last_byte_time  <= '0;
            r_last_frame_time <= '0;
            r_word            <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap_limit <= i_cfg_wdata;
            end
            if (i_cmd.take_byte) begin
                r_byte_count     <= n_byte_count;
                r_last_byte_time <= i_time_now;
            end
            if (i_cmd.commit_frame) begin
                r_last_frame_time <= r_now;
                r_word            <= '0;
            end else if (i_cmd.load_out) begin
                r_word <= r_word + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_zero <= pos_out;
        if (i_cmd.take_byte) begin
            r_now <= i_time_now;
            if (cnt_eff == '0) begin
                r_s1 <= i_rx_byte;
            end
            if (cnt_eff == rcsfd_pkg::ADDR_W'(1)) begin
                r_s2 <= i_rx_byte;
            end
        end
        if (i_cmd.commit_frame) begin
            r_interval <= r_now - r_last_frame_time;
        end
        if (i_cmd.latch_hi) begin
            r_hi <= rd_byte;
        end
        // next frame may commit while the last result still waits
        if (i_cmd.load_out) begin
            r_chan         <= chan;
            r_value        <= value;
            r_res_interval <= r_interval;
            r_last         <= (r_word == rcsfd_pkg::WORD_W'(rcsfd_pkg::WORDS_PER_FRAME - 1));
        end
    end

    always_comb begin
        o_sts.frame_full = full;
        o_sts.hdr_ok     = (r_s1 == rcsfd_pkg::STATUS_FIRST) &&
                           (r_s2 == rcsfd_pkg::STATUS_SECOND);
        o_sts.word_last  = (r_word == rcsfd_pkg::WORD_W'(rcsfd_pkg::WORDS_PER_FRAME - 1));
        o_sts.out_busy   = r_out_valid && i_out_stall;
    end

    assign o_out_valid      = r_out_valid;
    assign o_channel_index  = r_chan;
    assign o_channel_value  = r_value;
    assign o_frame_interval = r_res_interval;
    assign o_frame_last     = r_last;

endmodule

[rtl/core/rc_satellite_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rc_satellite_frame_decoder
// Serial frame decoder for RC satellite receivers: bytes in, channels out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  in       | request   | i_in_valid / o_in_stall | i_rx_byte, i_time_now
//  out      | result    | o_out_valid/i_out_stall | o_channel_index, o_channel_value,
//           |           |                         | o_frame_interval, o_frame_last
//  cfg      | write     | i_cfg_we                | i_cfg_wdata (gap limit)
//
//  A byte request is taken in the cycle it is presented; a byte that does not
//  close a frame leaves the block ready again on the next cycle.
//  A byte that closes a frame is followed by the header check (a bad header
//  ends there), then per word by two reads through the one read port of the
//  frame store (states RD_HI and RD_LO) plus the load of the result register
//  (state LOAD).
//  The result register decouples the sides: once the last word is loaded, new
//  bytes are taken while it waits; a stalled result only holds the sequencer
//  when the next word is ready to load.
//  Reset (i_rst_n, synchronous, active low) clears the byte count, both time
//  stamps, the gap limit (back to 2500) and the state; the store needs none.
// ----------------------------------------------------------------------------
module rc_satellite_frame_decoder (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [rcsfd_pkg::GAP_W-1:0]            i_cfg_wdata,
    // byte requests
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [rcsfd_pkg::BYTE_W-1:0]           i_rx_byte,
    input  logic [rcsfd_pkg::TIME_W-1:0]           i_time_now,
    // channel results
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [rcsfd_pkg::CHAN_W-1:0]           o_channel_index,
    output logic signed [rcsfd_pkg::VALUE_W-1:0]   o_channel_value,
    output logic [rcsfd_pkg::TIME_W-1:0]           o_frame_interval,
    output logic                                   o_frame_last
);

    rcsfd_pkg::t_cmd cmd;
    rcsfd_pkg::t_sts sts;

    // sequencer: intake, header check, word read/emit
    rcsfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage, gap timing and decode
    rcsfd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_rx_byte        (i_rx_byte),
        .i_time_now       (i_time_now),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_channel_index  (o_channel_index),
        .o_channel_value  (o_channel_value),
        .o_frame_interval (o_frame_interval),
        .o_frame_last     (o_frame_last)
    );

endmodule
